>>> rtl/dqpr_pkg.sv
`default_nettype none

package dqpr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int REQ_W     = 2;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 5;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 2'd0,
    REQ_INS_BACK  = 2'd1,
    REQ_REMOVE_AT = 2'd2,
    REQ_POP_FRONT = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/dqpr_if.sv
`default_nettype none

interface dqpr_req_if;
  logic                               valid;
  logic                               ready;
  logic [dqpr_pkg::REQ_W-1:0]         req_type;
  logic signed [dqpr_pkg::VAL_W-1:0]  item_value;
  logic [dqpr_pkg::POS_W-1:0]         position;

  modport source (output valid, req_type, item_value, position, input ready);
  modport sink   (input valid, req_type, item_value, position, output ready);
endinterface

interface dqpr_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [dqpr_pkg::VAL_W-1:0]  removed_value;
  logic [1:0]                         status;
  logic [dqpr_pkg::CNT_OUT_W-1:0]     element_count;

  modport source (output valid, removed_value, status, element_count, input ready);
  modport sink   (input valid, removed_value, status, element_count, output ready);
endinterface

`default_nettype wire

>>> rtl/dqpr_ctrl.sv
`default_nettype none

module dqpr_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dqpr_pkg::cmd_t      cmd
);

  dqpr_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dqpr_pkg::S_IDLE: begin
        if (in_valid) state_nxt = dqpr_pkg::S_EXEC;
      end
      dqpr_pkg::S_EXEC: begin
        if (slot_free) state_nxt = dqpr_pkg::S_IDLE;
      end
      default: state_nxt = dqpr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state_r)
      dqpr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      dqpr_pkg::S_EXEC: begin
        cmd.exec = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqpr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/dqpr_dpath.sv
`default_nettype none

module dqpr_dpath #(
  parameter int DEPTH = dqpr_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire dqpr_pkg::cmd_t                      cmd,
  input  wire logic [dqpr_pkg::REQ_W-1:0]          req_type,
  input  wire logic signed [dqpr_pkg::VAL_W-1:0]   item_value,
  input  wire logic [dqpr_pkg::POS_W-1:0]          position,
  output logic signed [dqpr_pkg::VAL_W-1:0]        removed_value,
  output logic [1:0]                               status,
  output logic [dqpr_pkg::CNT_OUT_W-1:0]           element_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (CNT_W > dqpr_pkg::POS_W) ? CNT_W : dqpr_pkg::POS_W;

  dqpr_pkg::req_t                     req_r;
  logic signed [dqpr_pkg::VAL_W-1:0]  val_r;
  logic [dqpr_pkg::POS_W-1:0]         pos_r;
  logic signed [dqpr_pkg::VAL_W-1:0]  ent_r   [DEPTH];
  logic signed [dqpr_pkg::VAL_W-1:0]  ent_nxt [DEPTH];
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;

  logic signed [dqpr_pkg::VAL_W-1:0]  rem_r, rem_nxt;
  dqpr_pkg::status_t                  st_r, st_nxt;
  logic [dqpr_pkg::CNT_OUT_W-1:0]     ecnt_r;

  logic             full, empty, bad_pos;
  logic [CMP_W-1:0] pos_ext, cnt_ext, idx_wide;
  logic [IDX_W-1:0] rm_idx, tail_idx;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pos_ext  = CMP_W'(pos_r);
  assign cnt_ext  = CMP_W'(cnt_r);
  assign bad_pos  = (pos_ext == '0) || (pos_ext > cnt_ext);
  assign idx_wide = pos_ext - CMP_W'(1);
  assign tail_idx = cnt_ext[IDX_W-1:0];

  always_comb begin
    if (req_r == dqpr_pkg::REQ_POP_FRONT) begin
      rm_idx = '0;
    end else begin
      rm_idx = idx_wide[IDX_W-1:0];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = '0;
    st_nxt  = dqpr_pkg::ST_OK;
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    case (req_r)
      dqpr_pkg::REQ_INS_FRONT: begin
        if (full) begin
          st_nxt = dqpr_pkg::ST_FULL;
        end else begin
          ent_nxt[0] = val_r;
          for (int i = 1; i < DEPTH; i++) begin
            ent_nxt[i] = ent_r[i-1];
          end
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      dqpr_pkg::REQ_INS_BACK: begin
        if (full) begin
          st_nxt = dqpr_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (IDX_W'(i) == tail_idx) ent_nxt[i] = val_r;
          end
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        if (empty) begin
          st_nxt = dqpr_pkg::ST_EMPTY;
        end else if (req_r == dqpr_pkg::REQ_REMOVE_AT && bad_pos) begin
          st_nxt = dqpr_pkg::ST_BADPOS;
        end else begin
          rem_nxt = ent_r[rm_idx];
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (IDX_W'(i) >= rm_idx) ent_nxt[i] = ent_r[i+1];
          end
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.exec) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= dqpr_pkg::req_t'(req_type);
      val_r <= item_value;
      pos_r <= position;
    end
    if (cmd.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
      rem_r  <= rem_nxt;
      st_r   <= st_nxt;
      ecnt_r <= dqpr_pkg::CNT_OUT_W'(CMP_W'(cnt_nxt));
    end
  end

  assign removed_value = rem_r;
  assign status        = st_r;
  assign element_count = ecnt_r;

endmodule

`default_nettype wire

>>> rtl/deque_with_positional_remove_top.sv
`default_nettype none
// A result is registered in the execute step, after its request beat is captured; execution
// waits while the previous result still waits to be taken.
// A new request is taken only in the capture step, once the previous one has executed;
// the list entries are updated in the execute step.
// A request is taken while an earlier result still waits in the output register.
// Reset clears the entry count and the result valid flag; stored entries are not cleared.

module deque_with_positional_remove_top #(
  parameter int DEPTH = dqpr_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  dqpr_req_if.sink   in_ch,
  dqpr_rsp_if.source out_ch
);

  dqpr_pkg::cmd_t cmd;
  logic           in_ready;
  logic           out_valid;

  dqpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  dqpr_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .req_type      (in_ch.req_type),
    .item_value    (in_ch.item_value),
    .position      (in_ch.position),
    .removed_value (out_ch.removed_value),
    .status        (out_ch.status),
    .element_count (out_ch.element_count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
